// File: hw/rtl/backbone_hbond_energy_test_defines.svh
// Assertion macros shared by the block's modules.
`ifndef BACKBONE_HBOND_ENERGY_TEST_DEFINES_SVH
`define BACKBONE_HBOND_ENERGY_TEST_DEFINES_SVH
`ifndef SYNTH
// Checked on every rising edge outside reset.
`define HBE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hbond energy check failed");
// Checked on every rising edge, reset included.
`define HBE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hbond energy check failed");
`else
`define HBE_ASSERT(lbl, prop)
`define HBE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/hbe_pkg.sv
package hbe_pkg;

  localparam int COORD_BITS   = 20;
  localparam int INDEX_BITS   = 16;
  localparam int RES_BITS     = 16;
  localparam int ENERGY_BITS  = 16;
  localparam int WIDE_BITS    = 34;
  localparam int INV_ONE_LOG  = 24;
  localparam int ABS_BITS     = INV_ONE_LOG + 1;
  localparam int SQ_BITS      = 2 * ABS_BITS;
  localparam int ROOT_BITS    = ABS_BITS;
  localparam int INV_BITS     = ABS_BITS;
  localparam int SUM_BITS     = INV_BITS + 2;
  localparam int PROD_BITS    = SUM_BITS + 17;
  localparam int LANE_LAT     = 3 + 2 * ROOT_BITS;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_BITS = 8;

  localparam logic [WIDE_BITS-1:0] INV_ONE = WIDE_BITS'(1) << INV_ONE_LOG;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FACTOR = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUTOFF = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MINSEP = 8'd2;

  localparam logic [15:0]        FACTOR_RESET = 16'd7139;
  localparam logic signed [15:0] CUTOFF_RESET = -16'sd128;
  localparam logic [3:0]         MINSEP_RESET = 4'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } xyz_t;

  typedef struct packed {
    logic                  operation;
    logic [INDEX_BITS-1:0] residue_index;
    coord_t                first_x;
    coord_t                first_y;
    coord_t                first_z;
    coord_t                second_x;
    coord_t                second_y;
    coord_t                second_z;
  } in_item_t;

  typedef struct packed {
    logic                          hbond_found;
    logic signed [ENERGY_BITS-1:0] pair_energy;
    logic [RES_BITS-1:0]           donor_residue;
    logic [RES_BITS-1:0]           acceptor_residue;
    logic                          too_close;
  } out_item_t;

  typedef struct packed {
    logic                  held;
    xyz_t                  carbon;
    xyz_t                  oxygen;
    xyz_t                  nitrogen;
    xyz_t                  hydrogen;
    logic [INDEX_BITS-1:0] donor;
    logic [INDEX_BITS-1:0] acceptor;
  } job_t;

  typedef struct packed {
    logic [15:0]        factor;
    logic signed [15:0] cutoff;
    logic [3:0]         min_sep;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic                held;
    logic                close;
    logic [RES_BITS-1:0] donor;
    logic [RES_BITS-1:0] acceptor;
  } meta_t;

endpackage

// File: hw/rtl/backbone_hbond_energy_test.sv
// Backbone hydrogen-bond energy test. A load request (operation 0) stores
// one CO residue: its index and its carbon and oxygen coordinates; it gives
// no result. Each test request (operation 1) brings one NH residue and gives
// exactly one result: the electrostatic energy
// factor * (1/rON + 1/rCH - 1/rOH - 1/rCN) in signed Q8 kcal/mol, saturated
// to 16 bits, a bond flag when that energy is strictly below the cutoff and
// the residue indices differ by more than the minimum separation, and a
// too_close flag when they do not. A test before any load reports no bond
// and zero energy. Coordinates are signed Q8 Angstrom. The block takes one
// request per cycle for as long as results are taken; a test request's
// result is computed by the four distance lanes, each of which runs three
// stages of differences and squares, a 25-stage square root and a 25-stage
// reciprocal divider, followed by the sum, the multiply by the factor and the
// result register. A four-entry queue between the front end and the
// arithmetic pipeline lets test requests keep flowing in until it is full
// while the output is stalled. The configuration port is always ready;
// write it only while the block is idle.
module backbone_hbond_energy_test
  import hbe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data
);

  // Configuration registers.
  cfg_t cfg_r;

  // Front end to queue, and queue to the arithmetic pipeline.
  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic q_pop;

  assign cfg_ready = 1'b1;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.factor  <= FACTOR_RESET;
      cfg_r.cutoff  <= CUTOFF_RESET;
      cfg_r.min_sep <= MINSEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FACTOR: cfg_r.factor  <= cfg_data;
        CFG_CUTOFF: cfg_r.cutoff  <= $signed(cfg_data);
        CFG_MINSEP: cfg_r.min_sep <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // The front end holds the loaded CO residue and turns each test request
  // into a complete job for the queue.
  hbe_front u_front (
    .clk,
    .rst_n,
    .in_valid_i (in_valid),
    .in_data_i  (in_data),
    .in_ready_o (in_ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  hbe_queue u_queue (
    .clk,
    .rst_n,
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_job)
  );

  // The back end is one pipeline that advances whenever its result register
  // is empty or being taken.
  hbe_back u_back (
    .clk,
    .rst_n,
    .cfg_i       (cfg_r),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

endmodule

// File: hw/rtl/hbe_front.sv
module hbe_front
  import hbe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_ready_o,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     job_o
);

  // Held CO residue.
  xyz_t                  carbon_r;
  xyz_t                  oxygen_r;
  logic [INDEX_BITS-1:0] donor_r;
  logic                  held_r;
  logic                  accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (in_data_i.operation == OP_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 1'b0;
      donor_r  <= '0;
      carbon_r <= '0;
      oxygen_r <= '0;
    end else if (accept && (in_data_i.operation == OP_LOAD)) begin
      held_r   <= 1'b1;
      donor_r  <= in_data_i.residue_index;
      carbon_r <= '{in_data_i.first_x, in_data_i.first_y, in_data_i.first_z};
      oxygen_r <= '{in_data_i.second_x, in_data_i.second_y, in_data_i.second_z};
    end
  end

  always_comb begin
    job_o.held     = held_r;
    job_o.carbon   = carbon_r;
    job_o.oxygen   = oxygen_r;
    job_o.nitrogen = '{in_data_i.first_x, in_data_i.first_y, in_data_i.first_z};
    job_o.hydrogen = '{in_data_i.second_x, in_data_i.second_y, in_data_i.second_z};
    job_o.donor    = donor_r;
    job_o.acceptor = in_data_i.residue_index;
  end

endmodule

// File: hw/rtl/hbe_queue.sv
`include "backbone_hbond_energy_test_defines.svh"
module hbe_queue
  import hbe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output job_t data_o
);

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS:0]   count_r;

  assign valid_o = (count_r != '0);
  assign full_o  = (count_r == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign data_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `HBE_ASSERT(a_no_overflow, !(push_i && full_o))
  `HBE_ASSERT(a_no_underflow, !(pop_i && !valid_o))
  `HBE_ASSERT(a_count_bound, count_r <= (QPTR_BITS + 1)'(QUEUE_DEPTH))

endmodule

// File: hw/rtl/hbe_lane.sv
module hbe_lane
  import hbe_pkg::*;
(
  input  logic                clk,
  input  logic                en_i,
  input  xyz_t                a_i,
  input  xyz_t                b_i,
  output logic [INV_BITS-1:0] inv_o
);

  coord_t                      ca [3];
  coord_t                      cb [3];
  logic signed [WIDE_BITS-1:0] diff [3];
  logic [WIDE_BITS-1:0]        ad [3];
  logic [2:0]                  far_c;

  logic [ABS_BITS-1:0] abs_r [3];
  logic                far1_r;
  logic [SQ_BITS-1:0]  sq_r [3];
  logic                far2_r;
  logic [SQ_BITS-1:0]  r2_r;
  logic                far3_r;

  // Square root, one result bit per stage.
  logic [SQ_BITS-1:0]   rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  logic                 sfar_r [ROOT_BITS];

  // Reciprocal by restoring division, one quotient bit per stage.
  logic [ROOT_BITS-1:0] drem_r [ROOT_BITS];
  logic [ROOT_BITS-1:0] dsor_r [ROOT_BITS];
  logic [ROOT_BITS-1:0] quo_r  [ROOT_BITS];
  logic                 dfar_r [ROOT_BITS];

  assign ca[0] = a_i.x;
  assign ca[1] = a_i.y;
  assign ca[2] = a_i.z;
  assign cb[0] = b_i.x;
  assign cb[1] = b_i.y;
  assign cb[2] = b_i.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = WIDE_BITS'(ca[k]) - WIDE_BITS'(cb[k]);
      ad[k]    = diff[k][WIDE_BITS-1] ? WIDE_BITS'(-diff[k]) : WIDE_BITS'(diff[k]);
      far_c[k] = ad[k] > INV_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        abs_r[k] <= ad[k][ABS_BITS-1:0];
        sq_r[k]  <= abs_r[k] * abs_r[k];
      end
      far1_r <= |far_c;
      far2_r <= far1_r;
      r2_r   <= sq_r[0] + sq_r[1] + sq_r[2];
      far3_r <= far2_r;
    end
  end

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
    localparam int B = ROOT_BITS - 1 - g;
    logic [SQ_BITS-1:0]   rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic                 far_in;
    logic [SQ_BITS+1:0]   test;
    logic                 ge;

    if (g == 0) begin : g_first
      assign rem_in  = r2_r;
      assign root_in = '0;
      assign far_in  = far3_r;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign far_in  = sfar_r[g-1];
    end

    assign test = ((SQ_BITS + 2)'(root_in) << (B + 1)) | ((SQ_BITS + 2)'(1) << (2 * B));
    assign ge   = {2'b00, rem_in} >= test;

    always_ff @(posedge clk) begin
      if (en_i) begin
        rem_r[g]  <= ge ? (rem_in - test[SQ_BITS-1:0]) : rem_in;
        root_r[g] <= ge ? (root_in | (ROOT_BITS'(1) << B)) : root_in;
        sfar_r[g] <= far_in;
      end
    end
  end

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_div
    localparam int B = ROOT_BITS - 1 - g;
    logic [ROOT_BITS-1:0] drem_in;
    logic [ROOT_BITS-1:0] dsor_in;
    logic [ROOT_BITS-1:0] quo_in;
    logic                 far_in;
    logic [ROOT_BITS:0]   shifted;
    logic                 ge;

    if (g == 0) begin : g_first
      assign drem_in = '0;
      // A zero distance gives the same inverse as a distance of one step.
      assign dsor_in = (root_r[ROOT_BITS-1] == '0) ? ROOT_BITS'(1) : root_r[ROOT_BITS-1];
      assign quo_in  = '0;
      assign far_in  = sfar_r[ROOT_BITS-1];
    end else begin : g_next
      assign drem_in = drem_r[g-1];
      assign dsor_in = dsor_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign far_in  = dfar_r[g-1];
    end

    assign shifted = {drem_in, 1'(B == INV_ONE_LOG)};
    assign ge      = shifted >= {1'b0, dsor_in};

    always_ff @(posedge clk) begin
      if (en_i) begin
        drem_r[g] <= ge ? ROOT_BITS'(shifted - {1'b0, dsor_in}) : ROOT_BITS'(shifted);
        dsor_r[g] <= dsor_in;
        quo_r[g]  <= ge ? (quo_in | (ROOT_BITS'(1) << B)) : quo_in;
        dfar_r[g] <= far_in;
      end
    end
  end

  assign inv_o = dfar_r[ROOT_BITS-1] ? '0 : INV_BITS'(quo_r[ROOT_BITS-1]);

endmodule

// File: hw/rtl/hbe_back.sv
`include "backbone_hbond_energy_test_defines.svh"
module hbe_back
  import hbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic signed [PROD_BITS:0] HALF = (PROD_BITS + 1)'(32768);
  localparam logic signed [PROD_BITS:0] EMAX = (PROD_BITS + 1)'(32767);
  localparam logic signed [PROD_BITS:0] EMIN = -(PROD_BITS + 1)'(32768);

  logic                  adv;
  logic [INDEX_BITS-1:0] idx_gap;
  meta_t                 entry;
  logic [INV_BITS-1:0]   inv [4];

  meta_t                       meta_r [LANE_LAT];
  meta_t                       meta_s_r;
  meta_t                       meta_p_r;
  logic signed [SUM_BITS-1:0]  sum_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic                        out_valid_r;
  out_item_t                   out_data_r;

  logic signed [PROD_BITS:0]       rnd;
  logic signed [PROD_BITS:0]       qv;
  logic signed [ENERGY_BITS-1:0]   energy;
  out_item_t                       out_nxt;

  assign adv         = !out_valid_r || out_ready_i;
  assign job_pop_o   = adv && job_valid_i;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  always_comb begin
    idx_gap = (job_i.donor >= job_i.acceptor) ? (job_i.donor - job_i.acceptor)
                                              : (job_i.acceptor - job_i.donor);
    entry.valid    = job_pop_o;
    entry.held     = job_i.held;
    entry.close    = !(idx_gap > INDEX_BITS'(cfg_i.min_sep));
    entry.donor    = RES_BITS'(job_i.donor);
    entry.acceptor = RES_BITS'(job_i.acceptor);
  end

  hbe_lane u_lane_on (.clk, .en_i(adv), .a_i(job_i.oxygen), .b_i(job_i.nitrogen),
                      .inv_o(inv[0]));
  hbe_lane u_lane_ch (.clk, .en_i(adv), .a_i(job_i.carbon), .b_i(job_i.hydrogen),
                      .inv_o(inv[1]));
  hbe_lane u_lane_oh (.clk, .en_i(adv), .a_i(job_i.oxygen), .b_i(job_i.hydrogen),
                      .inv_o(inv[2]));
  hbe_lane u_lane_cn (.clk, .en_i(adv), .a_i(job_i.carbon), .b_i(job_i.nitrogen),
                      .inv_o(inv[3]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANE_LAT; k++) begin
        meta_r[k] <= '0;
      end
      meta_s_r    <= '0;
      meta_p_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      meta_r[0] <= entry;
      for (int k = 1; k < LANE_LAT; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
      meta_s_r    <= meta_r[LANE_LAT-1];
      meta_p_r    <= meta_s_r;
      out_valid_r <= meta_p_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= $signed(SUM_BITS'(inv[0])) + $signed(SUM_BITS'(inv[1]))
             - $signed(SUM_BITS'(inv[2])) - $signed(SUM_BITS'(inv[3]));
      prod_r     <= $signed({1'b0, cfg_i.factor}) * sum_r;
      out_data_r <= out_nxt;
    end
  end

  always_comb begin
    rnd = (PROD_BITS + 1)'(prod_r) + HALF;
    qv  = rnd >>> 16;
    if (qv > EMAX) begin
      energy = ENERGY_BITS'(EMAX);
    end else if (qv < EMIN) begin
      energy = ENERGY_BITS'(EMIN);
    end else begin
      energy = ENERGY_BITS'(qv);
    end
    out_nxt.hbond_found      = meta_p_r.held && !meta_p_r.close && (energy < cfg_i.cutoff);
    out_nxt.pair_energy      = meta_p_r.held ? energy : '0;
    out_nxt.donor_residue    = meta_p_r.held ? meta_p_r.donor : '0;
    out_nxt.acceptor_residue = meta_p_r.acceptor;
    out_nxt.too_close        = meta_p_r.held && meta_p_r.close;
  end

  `HBE_ASSERT(a_pop_needs_advance, !job_pop_o || adv)
  `HBE_ASSERT(a_result_held, out_valid_r && !out_ready_i |=> out_valid_r)
  `HBE_ASSERT(a_close_no_bond, !(out_valid_r && out_data_r.too_close && out_data_r.hbond_found))

endmodule

// File: tb/sv/hbond_energy_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels of the hydrogen-bond
// energy block, predicts every result and compares it with what comes out.
module hbond_energy_checker
  import hbe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  in_item_t                in_data,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  out_item_t               out_data,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data,
  output int                      fail_count,
  output int                      pending
);

  localparam longint UNIT_INV = 64'sd16777216;

  out_item_t          expected_results[$];
  xyz_t               carbon_pos, oxygen_pos;
  logic [15:0]        donor_idx;
  logic               co_loaded;
  logic [15:0]        factor_reg;
  logic signed [15:0] cutoff_reg;
  logic [3:0]         min_sep_reg;
  int                 errors;

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000000000000000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Q16 inverse distance between two Q8 points.
  function automatic longint inverse_distance(xyz_t a, xyz_t b);
    longint d[3];
    longint unsigned r2, s;
    d[0] = longint'(a.x) - longint'(b.x);
    d[1] = longint'(a.y) - longint'(b.y);
    d[2] = longint'(a.z) - longint'(b.z);
    r2 = 0;
    foreach (d[k]) begin
      if (d[k] < 0) d[k] = -d[k];
      if (d[k] > UNIT_INV) return 0;
      r2 += longint'(d[k]) * longint'(d[k]);
    end
    s = floor_root(r2);
    if (s == 0) return UNIT_INV;
    return longint'(unsigned'(UNIT_INV) / s);
  endfunction

  function automatic out_item_t predict_pair(in_item_t req);
    out_item_t res;
    xyz_t      n_pos, h_pos;
    longint    total, energy, gap;
    n_pos = '{req.first_x, req.first_y, req.first_z};
    h_pos = '{req.second_x, req.second_y, req.second_z};
    res = '0;
    res.acceptor_residue = req.residue_index;
    if (!co_loaded) return res;
    total = inverse_distance(oxygen_pos, n_pos) + inverse_distance(carbon_pos, h_pos)
          - inverse_distance(oxygen_pos, h_pos) - inverse_distance(carbon_pos, n_pos);
    // Round the Q24 product to Q8, halves going up, then saturate.
    energy = (longint'(factor_reg) * total + 64'sd32768) >>> 16;
    if (energy > 32767) energy = 32767;
    if (energy < -32768) energy = -32768;
    gap = longint'(donor_idx) - longint'(req.residue_index);
    if (gap < 0) gap = -gap;
    res.too_close        = !(gap > longint'(min_sep_reg));
    res.pair_energy      = energy[15:0];
    res.donor_residue    = donor_idx;
    res.hbond_found      = !res.too_close && (energy < longint'(cutoff_reg));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t: result %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      expected_results.delete();
      carbon_pos  = '0;
      oxygen_pos  = '0;
      donor_idx   = '0;
      co_loaded   = 1'b0;
      factor_reg  = FACTOR_RESET;
      cutoff_reg  = CUTOFF_RESET;
      min_sep_reg = MINSEP_RESET;
      errors      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FACTOR: factor_reg  = cfg_data;
          CFG_CUTOFF: cutoff_reg  = cfg_data;
          CFG_MINSEP: min_sep_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          want = expected_results.pop_front();
          if (out_data.hbond_found != want.hbond_found)
            report_mismatch("hbond_found", out_data.hbond_found, want.hbond_found);
          if (out_data.pair_energy != want.pair_energy)
            report_mismatch("pair_energy", out_data.pair_energy, want.pair_energy);
          if (out_data.donor_residue != want.donor_residue)
            report_mismatch("donor_residue", out_data.donor_residue, want.donor_residue);
          if (out_data.acceptor_residue != want.acceptor_residue)
            report_mismatch("acceptor_residue", out_data.acceptor_residue,
                            want.acceptor_residue);
          if (out_data.too_close != want.too_close)
            report_mismatch("too_close", out_data.too_close, want.too_close);
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_LOAD) begin
          carbon_pos = '{in_data.first_x, in_data.first_y, in_data.first_z};
          oxygen_pos = '{in_data.second_x, in_data.second_y, in_data.second_z};
          donor_idx  = in_data.residue_index;
          co_loaded  = 1'b1;
        end else begin
          expected_results.push_back(predict_pair(in_data));
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the hydrogen-bond energy block. The checker
// beside the block does all prediction and comparison.
module tb_top
  import hbe_pkg::*;
();

  // An index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 8'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  in_item_t    in_data;
  logic        out_valid, out_ready;
  out_item_t   out_data;
  logic        cfg_valid, cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, pending;

  // Idling switches and the long receiver hold-off request.
  bit send_gaps, take_gaps, hold_request;
  int cycle_count;

  backbone_hbond_energy_test i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  hbond_energy_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle guard: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request so
  // that the internal queue fills and the block pushes back on requests.
  initial begin
    int hold_left, burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left    = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ready <= 1'b0;
      end else if (take_gaps && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one request and holds it until it is taken. Valid is left high so
  // that the next request can follow in the very next cycle.
  task automatic send_request(in_item_t req);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every outstanding result has arrived, then
  // lets the pipeline run dry in case a load is still in flight.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write, after which valid is dropped again on the register channel.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] factor, logic signed [15:0] cutoff,
                          logic [3:0] min_sep);
    write_reg(CFG_FACTOR, factor);
    write_reg(CFG_CUTOFF, cutoff);
    write_reg(CFG_MINSEP, {12'd0, min_sep});
  endtask

  function automatic in_item_t make_req(logic op, logic [15:0] idx, xyz_t a, xyz_t b);
    in_item_t req;
    req.operation     = op;
    req.residue_index = idx;
    req.first_x  = a.x;
    req.first_y  = a.y;
    req.first_z  = a.z;
    req.second_x = b.x;
    req.second_y = b.y;
    req.second_z = b.z;
    return req;
  endfunction

  function automatic xyz_t near_point(xyz_t p, int spread);
    xyz_t q;
    q.x = p.x + coord_t'($signed($urandom_range(0, 2 * spread)) - spread);
    q.y = p.y + coord_t'($signed($urandom_range(0, 2 * spread)) - spread);
    q.z = p.z + coord_t'($signed($urandom_range(0, 2 * spread)) - spread);
    return q;
  endfunction

  // Anywhere in the coordinate range, so every bit sees both values.
  function automatic xyz_t any_point();
    return xyz_t'({$urandom, $urandom});
  endfunction

  // Random traffic: mostly a CO load followed by a few NH tests placed at
  // bonding-like distances, with some full-range noise mixed in.
  task automatic random_traffic(int count);
    int          sent, tests;
    xyz_t        c_pos, o_pos, n_pos, h_pos, base;
    logic [15:0] donor;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        sent++;
      end else begin
        base  = '{coord_t'($signed($urandom_range(0, 800000)) - 400000),
                  coord_t'($signed($urandom_range(0, 800000)) - 400000),
                  coord_t'($signed($urandom_range(0, 800000)) - 400000)};
        c_pos = near_point(base, 100);
        o_pos = near_point(c_pos, 320);
        donor = $urandom;
        send_request(make_req(OP_LOAD, donor, c_pos, o_pos));
        sent++;
        tests = $urandom_range(1, 8);
        repeat (tests) begin
          n_pos = near_point(o_pos, 900);
          h_pos = near_point(n_pos, 260);
          send_request(make_req(OP_TEST, donor + 16'($urandom_range(0, 40)) - 16'd20,
                                n_pos, h_pos));
          sent++;
        end
      end
    end
  endtask

  initial begin
    xyz_t hi, lo, zero, mid;
    hi   = '{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF};
    lo   = '{20'sh80000, 20'sh80000, 20'sh80000};
    zero = '0;
    mid  = '{20'sd1000, -20'sd700, 20'sd300};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values. A test before any load
    // must come back with no bond and zero energy.
    send_request(make_req(OP_TEST, 16'hFFFF, hi, lo));
    send_request(make_req(OP_TEST, 16'h0000, mid, zero));
    // Far-apart extremes of the coordinate range.
    send_request(make_req(OP_LOAD, 16'd0, lo, hi));
    send_request(make_req(OP_TEST, 16'hFFFF, hi, lo));
    send_request(make_req(OP_TEST, 16'hFFFF, lo, hi));
    // Nitrogen on top of oxygen and hydrogen on top of carbon: zero distances.
    send_request(make_req(OP_LOAD, 16'd100, zero, mid));
    send_request(make_req(OP_TEST, 16'd110, mid, zero));
    // A pair at or inside the minimum separation is reported but not bonded; the last pair lies just beyond it.
    send_request(make_req(OP_TEST, 16'd102, mid, zero));
    send_request(make_req(OP_TEST, 16'd98, mid, zero));
    send_request(make_req(OP_TEST, 16'd103, mid, zero));
    // A bonding-like geometry, once well separated and once too close.
    send_request(make_req(OP_LOAD, 16'd50, '{20'sd0, 20'sd0, 20'sd0},
                          '{20'sd315, 20'sd0, 20'sd0}));
    send_request(make_req(OP_TEST, 16'd60, '{20'sd1060, 20'sd0, 20'sd0},
                          '{20'sd804, 20'sd0, 20'sd0}));
    send_request(make_req(OP_TEST, 16'd51, '{20'sd1060, 20'sd0, 20'sd0},
                          '{20'sd804, 20'sd0, 20'sd0}));
    drain();

    // Extreme registers: the largest factor, a cutoff nothing can beat and
    // the widest separation; the ignored index is written too.
    set_regs(16'hFFFF, -16'sd32768, 4'd15);
    write_reg(CFG_UNUSED, 16'h1234);
    send_request(make_req(OP_LOAD, 16'd200, zero, mid));
    send_request(make_req(OP_TEST, 16'd216, mid, zero));
    send_request(make_req(OP_TEST, 16'd215, zero, mid));
    random_traffic(200);
    drain();

    // Zero factor, zero cutoff and zero minimum separation, so only equal indices are too close.
    set_regs(16'd0, 16'sd0, 4'd0);
    send_request(make_req(OP_LOAD, 16'd7, zero, mid));
    send_request(make_req(OP_TEST, 16'd7, mid, zero));
    random_traffic(200);
    drain();

    // Large factor, zero cutoff; the receiver holds off for a long stretch
    // while requests keep coming with no sender gaps.
    set_regs(16'd40000, 16'sd0, 4'd1);
    send_gaps    = 1'b0;
    hold_request = 1'b1;
    random_traffic(200);
    send_gaps = 1'b1;
    drain();

    // Random register values within their ranges, the cutoff zero or negative.
    set_regs(16'($urandom), -16'($urandom_range(0, 32768)), 4'($urandom));
    random_traffic(200);
    drain();

    // Back to the reset values; the second half of the last part runs without idling on either side.
    set_regs(FACTOR_RESET, CUTOFF_RESET, MINSEP_RESET);
    random_traffic(150);
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    random_traffic(150);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
